// ===== hw/rtl/ads_pkg.sv =====
package ads_pkg;

    localparam int ADS_MAX_CHANNELS = 8;

    localparam int SAMPLE_W = 64;
    localparam int GAIN_W   = 16;
    localparam int FMT_W    = 3;
    localparam int CNT_W    = 4;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN          = 2'd2;

    // Sample format codes.
    localparam logic [FMT_W-1:0] FMT_S8  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_U8  = 3'd1;
    localparam logic [FMT_W-1:0] FMT_S16 = 3'd2;
    localparam logic [FMT_W-1:0] FMT_U16 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_S32 = 3'd4;
    localparam logic [FMT_W-1:0] FMT_U32 = 3'd5;
    localparam logic [FMT_W-1:0] FMT_S64 = 3'd6;
    localparam logic [FMT_W-1:0] FMT_U64 = 3'd7;

    // Format limits, held as 65-bit signed values so every format fits.
    localparam logic signed [64:0] LIM_S8_MIN  = -65'sd128;
    localparam logic signed [64:0] LIM_S8_MAX  = 65'sd127;
    localparam logic signed [64:0] LIM_U8_MAX  = 65'sd255;
    localparam logic signed [64:0] LIM_S16_MIN = -65'sd32768;
    localparam logic signed [64:0] LIM_S16_MAX = 65'sd32767;
    localparam logic signed [64:0] LIM_U16_MAX = 65'sd65535;
    localparam logic signed [64:0] LIM_S32_MIN = -65'sd2147483648;
    localparam logic signed [64:0] LIM_S32_MAX = 65'sd2147483647;
    localparam logic signed [64:0] LIM_U32_MAX = 65'sd4294967295;
    localparam logic signed [64:0] LIM_S64_MIN = 65'h1_8000_0000_0000_0000;
    localparam logic signed [64:0] LIM_S64_MAX = 65'h0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] LIM_U64_MAX = 65'h0_FFFF_FFFF_FFFF_FFFF;

    localparam logic signed [64:0] LIM_ZERO = 65'sd0;

    function automatic logic [SAMPLE_W-1:0] fmt_mask(input logic [FMT_W-1:0] fmt);
        logic [SAMPLE_W-1:0] m;
        unique case (fmt[2:1])
            2'd0:    m = 64'h0000_0000_0000_00FF;
            2'd1:    m = 64'h0000_0000_0000_FFFF;
            2'd2:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // Raw sample bits to a 65-bit signed value in the given format.
    function automatic logic signed [64:0] fmt_decode(input logic [SAMPLE_W-1:0] raw,
                                                      input logic [FMT_W-1:0] fmt);
        logic [SAMPLE_W-1:0] m;
        logic [SAMPLE_W-1:0] v;
        logic                sb;
        logic                neg;
        m = fmt_mask(fmt);
        v = raw & m;
        unique case (fmt[2:1])
            2'd0:    sb = v[7];
            2'd1:    sb = v[15];
            2'd2:    sb = v[31];
            default: sb = v[63];
        endcase
        neg = !fmt[0] && sb;
        if (neg)
        begin
            v = v | ~m;
        end
        return $signed({neg, v});
    endfunction

    function automatic logic signed [64:0] fmt_lim_hi(input logic [FMT_W-1:0] fmt);
        logic signed [64:0] l;
        unique case (fmt)
            FMT_S8:  l = LIM_S8_MAX;
            FMT_U8:  l = LIM_U8_MAX;
            FMT_S16: l = LIM_S16_MAX;
            FMT_U16: l = LIM_U16_MAX;
            FMT_S32: l = LIM_S32_MAX;
            FMT_U32: l = LIM_U32_MAX;
            FMT_S64: l = LIM_S64_MAX;
            FMT_U64: l = LIM_U64_MAX;
            default: l = LIM_U64_MAX;
        endcase
        return l;
    endfunction

    function automatic logic signed [64:0] fmt_lim_lo(input logic [FMT_W-1:0] fmt);
        logic signed [64:0] l;
        unique case (fmt)
            FMT_S8:  l = LIM_S8_MIN;
            FMT_S16: l = LIM_S16_MIN;
            FMT_S32: l = LIM_S32_MIN;
            FMT_S64: l = LIM_S64_MIN;
            default: l = LIM_ZERO;
        endcase
        return l;
    endfunction

endpackage

// ===== hw/rtl/ads_hist_ram.sv =====
module ads_hist_ram #(
    parameter int DEPTH  = ads_pkg::ADS_MAX_CHANNELS,
    parameter int ADDR_W = 3
) (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [ads_pkg::SAMPLE_W-1:0]  rd_data,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [ads_pkg::SAMPLE_W-1:0]  wr_data
);
    import ads_pkg::*;

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    // A read and a write to the same entry in one cycle return the old contents.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/audio_difference_sharpener.sv =====
// Difference sharpener for interleaved audio: each sample x of channel c becomes
// x + gain*(x - previous sample of c), gain in signed Q8.8, truncated toward zero
// and clamped to the configured format (tuser of the result flags a clamp). The
// block takes one item per clock unless a held result backs up to the input, and
// passes each item through stage 1, stage 2, stage 3 and the output register; a
// held result stalls only the full stages behind it, so the input stops once
// four items are waiting. Per-channel history sits in a small RAM that is read
// and rewritten in the cycle an item is accepted, so consecutive items need no
// interlock. An item with buffer_start set restarts the channel count, and the
// first frame of each buffer passes through unchanged while loading the history.
// Configuration may only be written while no item is in flight.
module audio_difference_sharpener #(
    parameter int MAX_CHANNELS = ads_pkg::ADS_MAX_CHANNELS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [63:0]                     s_tdata,   // [63:0] sample_in
    input  logic                            s_tuser,   // [0] buffer_start
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [63:0]                     m_tdata,   // [63:0] sample_out
    output logic                            m_tuser,   // [0] saturated
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ads_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [15:0]                     cfg_data
);
    import ads_pkg::*;

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // Configuration registers.
    logic [FMT_W-1:0]         fmt_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [GAIN_W-1:0] gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg  <= FMT_S16;
            cnt_reg  <= 4'd2;
            gain_reg <= 16'sd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SAMPLE_FORMAT: fmt_reg  <= cfg_data[FMT_W-1:0];
                CFG_CHANNEL_COUNT: cnt_reg  <= cfg_data[CNT_W-1:0];
                CFG_GAIN:          gain_reg <= $signed(cfg_data);
                default:           ;
            endcase
        end
    end

    // Pipeline flow control.
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic en1, en2, en3, en_o;
    logic accept;

    assign en_o     = !vo_reg || m_tready;
    assign en3      = !v3_reg || en_o;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign accept   = s_tvalid && s_tready;

    // Channel tracking.
    logic [CH_W-1:0] idx_reg, idx_next;
    logic            first_reg, first_next;
    logic [CH_W-1:0] ch;
    logic            first_cur;
    logic [6:0]      nch;
    logic [6:0]      idx_inc;

    always_comb
    begin
        if (cnt_reg == '0)
        begin
            nch = 7'd1;
        end
        else if (7'(cnt_reg) > 7'(MAX_CHANNELS))
        begin
            nch = 7'(MAX_CHANNELS);
        end
        else
        begin
            nch = 7'(cnt_reg);
        end

        ch        = s_tuser ? '0 : idx_reg;
        first_cur = s_tuser ? 1'b1 : first_reg;
        idx_inc   = 7'(ch) + 7'd1;

        idx_next   = idx_reg;
        first_next = first_reg;
        if (accept)
        begin
            if (idx_inc >= nch)
            begin
                idx_next   = '0;
                first_next = 1'b0;
            end
            else
            begin
                idx_next   = idx_inc[CH_W-1:0];
                first_next = first_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            idx_reg   <= idx_next;
            first_reg <= first_next;
        end
    end

    // History RAM: read the previous sample and store the new one together.
    logic [SAMPLE_W-1:0] in_masked;
    logic [SAMPLE_W-1:0] prev_raw;

    assign in_masked = s_tdata & fmt_mask(fmt_reg);

    ads_hist_ram #(
        .DEPTH  (MAX_CHANNELS),
        .ADDR_W (CH_W)
    ) u_hist (
        .clk     (clk),
        .rd_en   (en1),
        .rd_addr (ch),
        .rd_data (prev_raw),
        .wr_en   (accept),
        .wr_addr (ch),
        .wr_data (in_masked)
    );

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en1)  v1_reg <= s_tvalid;
            if (en2)  v2_reg <= v1_reg;
            if (en3)  v3_reg <= v2_reg;
            if (en_o) vo_reg <= v3_reg;
        end
    end

    // Stage 1: decoded sample, pass-through value, first-frame flag.
    logic signed [64:0]  s1_x_reg;
    logic [SAMPLE_W-1:0] s1_pass_reg;
    logic                s1_first_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_x_reg     <= fmt_decode(s_tdata, fmt_reg);
            s1_pass_reg  <= in_masked;
            s1_first_reg <= first_cur;
        end
    end

    // Stage 2: difference and two partial products of gain*d.
    logic signed [65:0]  d;
    logic signed [49:0]  pp_lo;
    logic signed [48:0]  pp_hi;
    logic signed [64:0]  s2_x_reg;
    logic signed [49:0]  s2_pplo_reg;
    logic signed [48:0]  s2_pphi_reg;
    logic [SAMPLE_W-1:0] s2_pass_reg;
    logic                s2_first_reg;

    assign d     = 66'(s1_x_reg) - 66'(fmt_decode(prev_raw, fmt_reg));
    assign pp_lo = 50'(gain_reg) * 50'($signed({1'b0, d[32:0]}));
    assign pp_hi = 49'(gain_reg) * 49'($signed(d[65:33]));

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_x_reg     <= s1_x_reg;
            s2_pplo_reg  <= pp_lo;
            s2_pphi_reg  <= pp_hi;
            s2_pass_reg  <= s1_pass_reg;
            s2_first_reg <= s1_first_reg;
        end
    end

    // Stage 3: 256*x + gain*d, exact.
    logic signed [81:0]  t_sum;
    logic signed [81:0]  s3_t_reg;
    logic [SAMPLE_W-1:0] s3_pass_reg;
    logic                s3_first_reg;

    assign t_sum = (82'(s2_x_reg) <<< 8) + 82'(s2_pplo_reg) + (82'(s2_pphi_reg) <<< 33);

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_t_reg     <= t_sum;
            s3_pass_reg  <= s2_pass_reg;
            s3_first_reg <= s2_first_reg;
        end
    end

    // Output stage: divide by 256 toward zero, then clamp.
    logic signed [73:0]  y;
    logic signed [73:0]  lim_hi;
    logic signed [73:0]  lim_lo;
    logic [SAMPLE_W-1:0] out_mask;
    logic [SAMPLE_W-1:0] out_data_next;
    logic                out_sat_next;
    logic [SAMPLE_W-1:0] out_data_reg;
    logic                out_sat_reg;

    always_comb
    begin
        y        = s3_t_reg[81:8] + 74'(s3_t_reg[81] && (s3_t_reg[7:0] != 8'd0));
        lim_hi   = 74'(fmt_lim_hi(fmt_reg));
        lim_lo   = 74'(fmt_lim_lo(fmt_reg));
        out_mask = fmt_mask(fmt_reg);
        priority if (s3_first_reg)
        begin
            out_data_next = s3_pass_reg;
            out_sat_next  = 1'b0;
        end
        else if (y < lim_lo)
        begin
            out_data_next = lim_lo[63:0] & out_mask;
            out_sat_next  = 1'b1;
        end
        else if (y > lim_hi)
        begin
            out_data_next = lim_hi[63:0] & out_mask;
            out_sat_next  = 1'b1;
        end
        else
        begin
            out_data_next = y[63:0] & out_mask;
            out_sat_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_o)
        begin
            out_data_reg <= out_data_next;
            out_sat_reg  <= out_sat_next;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

endmodule

// ===== hw/rtl/ads_checker.sv =====
module ads_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);
    // Items accepted whose results have not yet been taken.
    logic [2:0] pend_reg, pend_next;
    logic       in_acc, out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_acc && !out_acc)
        begin
            pend_next = pend_reg + 3'd1;
        end
        else if (!in_acc && out_acc)
        begin
            pend_next = pend_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != 3'd0)
        else $error("result offered with no item outstanding");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd4)
        else $error("more items in flight than pipeline stages");

    // With every stage full, only a result leaving makes room for a new item.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 3'd4 && !m_tready |-> !s_tready)
        else $error("input accepted with pipeline full");

endmodule

bind audio_difference_sharpener ads_checker u_ads_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/audio_difference_sharpener_tb.sv =====
module audio_difference_sharpener_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ads_pkg::*;

    // Index 3 has no register behind it; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [63:0] sample;
        logic        start;
    } sample_item_t;

    typedef struct packed {
        logic [63:0] sample;
        logic        clipped;
    } sharpened_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [63:0]          m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;

    sample_item_t pending_samples[$];
    sharpened_t   expected_out[$];
    sharpened_t   want;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_pushed = 0;
    int results_seen = 0;
    int mismatches = 0;
    logic hold_arm = 1'b0;
    logic out_hold = 1'b0;

    // Stimulus side: effective channel count, and a pending forced buffer start
    // that keeps any never-written history entry from being read.
    int   gen_chans = 2;
    logic restart_due = 1'b0;

    // Predictor state and configuration.
    logic [63:0]        history [ADS_MAX_CHANNELS];
    int                 chan_pos = 0;
    logic               first_frame = 1'b1;
    logic [FMT_W-1:0]   fmt_reg = FMT_S16;
    logic [CNT_W-1:0]   chan_reg = 4'd2;
    logic signed [15:0] gain_reg = 16'sd256;

    audio_difference_sharpener u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic sharpened_t sharpen(input logic [63:0] raw, input logic restart);
        sharpened_t         res;
        int                 width;
        logic               is_signed;
        logic [63:0]        mask;
        int                 nch;
        int                 ch;
        logic signed [95:0] x_val;
        logic signed [95:0] p_val;
        logic signed [95:0] acc;
        logic signed [95:0] half;
        logic signed [95:0] lim_hi;
        logic signed [95:0] lim_lo;
        case (fmt_reg)
            FMT_S8, FMT_U8:   width = 8;
            FMT_S16, FMT_U16: width = 16;
            FMT_S32, FMT_U32: width = 32;
            default:          width = 64;
        endcase
        is_signed = (fmt_reg == FMT_S8) || (fmt_reg == FMT_S16) ||
                    (fmt_reg == FMT_S32) || (fmt_reg == FMT_S64);
        mask = ~64'd0 >> (64 - width);
        if (chan_reg == 0)
            nch = 1;
        else if (chan_reg > ADS_MAX_CHANNELS)
            nch = ADS_MAX_CHANNELS;
        else
            nch = int'(chan_reg);
        if (restart)
        begin
            chan_pos = 0;
            first_frame = 1'b1;
        end
        ch = chan_pos;
        if (first_frame)
        begin
            res.sample = raw & mask;
            res.clipped = 1'b0;
        end
        else
        begin
            x_val = $signed({32'd0, raw & mask});
            p_val = $signed({32'd0, history[ch] & mask});
            if (is_signed && raw[width-1])
                x_val = x_val - ($signed(96'd1) <<< width);
            if (is_signed && history[ch][width-1])
                p_val = p_val - ($signed(96'd1) <<< width);
            // Signed division truncates toward zero, as the block must.
            acc = ((x_val <<< 8) + gain_reg * (x_val - p_val)) / 256;
            if (is_signed)
            begin
                half = $signed(96'd1) <<< (width - 1);
                lim_hi = half - 1;
                lim_lo = -half;
            end
            else
            begin
                lim_hi = $signed({32'd0, mask});
                lim_lo = '0;
            end
            res.clipped = 1'b0;
            if (acc < lim_lo)
            begin
                acc = lim_lo;
                res.clipped = 1'b1;
            end
            else if (acc > lim_hi)
            begin
                acc = lim_hi;
                res.clipped = 1'b1;
            end
            res.sample = acc[63:0] & mask;
        end
        history[ch] = raw & mask;
        if (chan_pos + 1 >= nch)
        begin
            chan_pos = 0;
            first_frame = 1'b0;
        end
        else
        begin
            chan_pos++;
        end
        return res;
    endfunction

    function automatic logic [63:0] pick_sample();
        logic [63:0] v;
        logic [63:0] keep;
        int          w;
        int          s;
        w = 8 << $urandom_range(3);
        keep = ~64'd0 >> (64 - w);
        case ($urandom_range(9))
            0, 1, 2, 3: v = {$urandom, $urandom};
            4, 5, 6:
            begin
                case ($urandom_range(3))
                    0:       v = 64'd1 << (w - 1);
                    1:       v = (64'd1 << (w - 1)) - 1;
                    2:       v = keep;
                    default: v = 64'd0;
                endcase
                if ($urandom_range(1) != 0)
                    v = v | ({$urandom, $urandom} & ~keep);
            end
            default:
            begin
                s = int'($urandom_range(600)) - 300;
                v = {{32{s[31]}}, s};
            end
        endcase
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_out.push_back(sharpen(s_tdata, s_tuser));
            if (!s_tvalid || s_tready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_samples[0].sample;
                    s_tuser <= pending_samples[0].start;
                    pending_samples.delete(0);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (expected_out.size() == 0)
                begin
                    $error("unexpected item: sample_out %h saturated %b", m_tdata, m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (m_tdata !== want.sample)
                    begin
                        $error("sample_out mismatch: expected %h, got %h", want.sample, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser !== want.clipped)
                    begin
                        $error("saturated mismatch: expected %b, got %b", want.clipped, m_tuser);
                        mismatches++;
                    end
                end
            end
            m_tready <= !out_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver stall so the pipeline fills and pushes back on the input.
    initial
    begin
        wait (hold_arm);
        @(posedge clk);
        out_hold <= 1'b1;
        repeat (300) @(posedge clk);
        out_hold <= 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("audio_difference_sharpener test failed");
        $finish;
    end

    task automatic push_sample(input logic [63:0] sample, input logic start);
        sample_item_t it;
        it.sample = sample;
        it.start = start | restart_due;
        restart_due = 1'b0;
        pending_samples.push_back(it);
        items_pushed++;
    endtask

    task automatic settle();
        while (results_seen != items_pushed) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        int eff;
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SAMPLE_FORMAT: fmt_reg = data[FMT_W-1:0];
            CFG_CHANNEL_COUNT: chan_reg = data[CNT_W-1:0];
            CFG_GAIN:          gain_reg = data;
            default:           ;
        endcase
        if (idx == CFG_CHANNEL_COUNT)
        begin
            if (data[3:0] == 0)
                eff = 1;
            else if (data[3:0] > ADS_MAX_CHANNELS)
                eff = ADS_MAX_CHANNELS;
            else
                eff = int'(data[3:0]);
            // More channels than the current buffer loaded: start a new buffer.
            if (eff > gen_chans)
                restart_due = 1'b1;
            gen_chans = eff;
        end
    endtask

    task automatic reconfigure();
        logic [15:0] g;
        int          s;
        if ($urandom_range(2) != 0)
            write_reg(CFG_SAMPLE_FORMAT, 16'($urandom_range(65535)));
        if ($urandom_range(2) != 0)
        begin
            if ($urandom_range(3) == 0)
                write_reg(CFG_CHANNEL_COUNT, 16'($urandom_range(65535)));
            else
                write_reg(CFG_CHANNEL_COUNT, 16'($urandom_range(1, 8)));
        end
        if ($urandom_range(2) != 0)
        begin
            case ($urandom_range(7))
                0: g = 16'h8000;
                1: g = 16'h7FFF;
                2: g = 16'h0000;
                3: g = 16'h0100;
                4:
                begin
                    s = int'($urandom_range(1024)) - 512;
                    g = s[15:0];
                end
                default: g = 16'($urandom_range(65535));
            endcase
            write_reg(CFG_GAIN, g);
        end
        if ($urandom_range(9) == 0)
            write_reg(CFG_UNUSED, 16'($urandom_range(65535)));
    endtask

    // Mostly whole buffers of whole frames, with stray buffer starts and
    // the odd partial frame mixed in.
    task automatic push_buffers(input int budget);
        int n;
        int len;
        n = 0;
        while (n < budget)
        begin
            len = gen_chans * $urandom_range(1, 6);
            if ($urandom_range(7) == 0)
                len += $urandom_range(gen_chans - 1);
            for (int k = 0; k < len; k++)
                push_sample(pick_sample(),
                            (k == 0) ? ($urandom_range(15) != 0) : ($urandom_range(63) == 0));
            n += len;
        end
    endtask

    initial
    begin
        int sent;
        int burst;
        int base;
        send_idle_pct = 20;
        recv_idle_pct = 87;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset setup: s16, two channels, unity gain; clamps at both ends.
        push_sample(64'hFFFF_FFFF_FFFF_7FFF, 1'b1);
        push_sample(64'h0123_4567_89AB_8000, 1'b0);
        push_sample(64'h0000_0000_0000_8000, 1'b0);
        push_sample(64'h0000_0000_0000_7FFF, 1'b0);
        push_sample(64'h0000_0000_0000_0000, 1'b0);
        push_sample(64'hFFFF_FFFF_FFFF_FFFB, 1'b0);
        settle();

        // Most negative gain, and a format switch that reinterprets the history.
        write_reg(CFG_GAIN, 16'h8000);
        write_reg(CFG_SAMPLE_FORMAT, {13'h1FFF, FMT_U8});
        write_reg(CFG_UNUSED, 16'hFFFF);
        push_sample(64'h0000_0000_0000_00FF, 1'b0);
        push_sample(64'h0000_0000_0000_0000, 1'b0);
        push_sample(64'hA5A5_A5A5_A5A5_A580, 1'b0);
        push_sample(64'h0000_0000_0000_007F, 1'b0);
        settle();

        // A channel count of zero behaves as one channel.
        write_reg(CFG_SAMPLE_FORMAT, {13'd0, FMT_S64});
        write_reg(CFG_GAIN, 16'h7FFF);
        write_reg(CFG_CHANNEL_COUNT, 16'h0000);
        push_sample(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        push_sample(64'h8000_0000_0000_0000, 1'b0);
        push_sample(64'h0000_0000_0000_0001, 1'b0);
        settle();

        // A count above the maximum behaves as the maximum.
        write_reg(CFG_SAMPLE_FORMAT, {13'h0AAA, FMT_U64});
        write_reg(CFG_CHANNEL_COUNT, 16'hFFFF);
        write_reg(CFG_GAIN, 16'hFF00);
        for (int k = 0; k < 10; k++)
            push_sample(pick_sample(), 1'b0);
        settle();

        // Shrink the frame while the channel position is already past the new count.
        write_reg(CFG_CHANNEL_COUNT, 16'd2);
        write_reg(CFG_SAMPLE_FORMAT, {13'd0, FMT_S32});
        push_sample(64'h0000_0000_8000_0000, 1'b0);
        push_sample(64'hFFFF_FFFF_7FFF_FFFF, 1'b0);
        push_sample(64'h0000_0000_0000_0003, 1'b0);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 20;
                    recv_idle_pct = 87;
                end
                1:
                begin
                    send_idle_pct = 87;
                    recv_idle_pct = 20;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < 310)
            begin
                settle();
                reconfigure();
                if (phase == 2)
                    hold_arm = 1'b1;
                burst = $urandom_range(20, 60);
                base = items_pushed;
                push_buffers(burst);
                sent += items_pushed - base;
            end
        end

        settle();
        if (mismatches == 0)
            $display("audio_difference_sharpener test passed");
        else
            $display("audio_difference_sharpener test failed");
        $finish;
    end

endmodule
